// ===== src/trk_pkg.sv =====
// ---------------------------------------------------------------------------
// trk_pkg: shared constants for the TextRank ranker
// Widths of the score, similarity, row sum and divider paths.
// ---------------------------------------------------------------------------
`default_nettype none

package trk_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int N_W       = IDX_W + 1;
    localparam int SIM_W     = 16;
    localparam int SCORE_W   = 24;
    localparam int RS_W      = 22;            // row sum, signed
    localparam int PROD_W    = SIM_W + SCORE_W;
    localparam int MAG_W     = PROD_W - 1;    // magnitude of a product
    localparam int ACC_W     = MAG_W + 1 + IDX_W;
    localparam int DCNT_W    = $clog2(MAG_W);
    localparam int D_W       = 16;
    localparam int THR_W     = 16;
    localparam int ITER_W    = 10;

    localparam logic signed [SCORE_W-1:0] ONE_Q16   = 24'sd65536;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_DAMPING    = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_MAX_ITER   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

// ===== src/trk_divider.sv =====
// ---------------------------------------------------------------------------
// trk_divider: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module trk_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [trk_pkg::MAG_W-1:0]     dividend,
    input  wire logic [trk_pkg::RS_W-1:0]      divisor,
    output logic                               busy,
    output logic                               done,
    output logic [trk_pkg::MAG_W-1:0]          quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [trk_pkg::DCNT_W-1:0]    cnt_reg;
    logic [trk_pkg::RS_W-1:0]      rem_reg;
    logic [trk_pkg::RS_W-1:0]      dsr_reg;
    logic [trk_pkg::MAG_W-1:0]     quo_reg;
    logic [trk_pkg::RS_W:0]        shifted;
    logic [trk_pkg::RS_W:0]        trial;

    assign shifted = {rem_reg, quo_reg[trk_pkg::MAG_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == trk_pkg::DCNT_W'(trk_pkg::MAG_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: shift in one dividend bit, keep the trial difference if it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[trk_pkg::RS_W])
            begin
                rem_reg <= trial[trk_pkg::RS_W-1:0];
                quo_reg <= {quo_reg[trk_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[trk_pkg::RS_W-1:0];
                quo_reg <= {quo_reg[trk_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/textrank_power_iteration_ranker_top.sv =====
// ---------------------------------------------------------------------------
// textrank_power_iteration_ranker_top: weighted PageRank sentence ranker
// Holds a similarity matrix in block memory, runs damped power iteration
// passes on a run item and emits the nodes from highest score to lowest.
// ---------------------------------------------------------------------------
//
//   channel | signals                                  | moves
//   --------+------------------------------------------+-----------------------
//   in      | in_valid/in_ready, opcode,row,col,sim.   | load or run item
//   out     | out_valid/out_ready, node_index,score,.. | one ranked node
//   cfg     | cfg_write, cfg_index, cfg_data           | register write, no wait
//
// A run item computes the row sums, then the damped passes, then the ranked
// order; the bit-serial divider (one quotient bit per cycle) sets the pass
// length. in_ready is high only while idle; the output register lets the
// next item in while the last node of a run still waits.
// Reset clears control and loads the configuration defaults; datapath registers and memories hold no reset value.
//
`default_nettype none

module textrank_power_iteration_ranker_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input items
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 opcode,
    input  wire logic [5:0]                           row,
    input  wire logic [5:0]                           col,
    input  wire logic signed [15:0]                   similarity,
    // result items
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [5:0]                                node_index,
    output logic signed [23:0]                        score,
    output logic                                      is_last,
    output logic                                      converged,
    output logic [9:0]                                iterations_used,
    // configuration
    input  wire logic                                 cfg_write,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [15:0]                          cfg_data
);

    localparam int IDX_W   = trk_pkg::IDX_W;
    localparam int N_W     = trk_pkg::N_W;
    localparam int SIM_W   = trk_pkg::SIM_W;
    localparam int SCORE_W = trk_pkg::SCORE_W;
    localparam int RS_W    = trk_pkg::RS_W;
    localparam int PROD_W  = trk_pkg::PROD_W;
    localparam int MAG_W   = trk_pkg::MAG_W;
    localparam int ACC_W   = trk_pkg::ACC_W;
    localparam int D_W     = trk_pkg::D_W;
    localparam int ITER_W  = trk_pkg::ITER_W;
    localparam int LO_W    = SCORE_W;                 // low slice of acc
    localparam int HI_W    = ACC_W - LO_W;            // signed high slice
    localparam int TOT_W   = 64;
    localparam int NV_W    = ACC_W + 1;
    localparam int DIF_W   = SCORE_W + 1;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_RS_RD    = 15'b000000000000010,
        ST_RS_ACC   = 15'b000000000000100,
        ST_P_RD     = 15'b000000000001000,
        ST_P_MUL    = 15'b000000000010000,
        ST_P_DSTART = 15'b000000000100000,
        ST_P_DWAIT  = 15'b000000001000000,
        ST_P_NEXT   = 15'b000000010000000,
        ST_P_OLD_RD = 15'b000000100000000,
        ST_P_MD1    = 15'b000001000000000,
        ST_P_MD2    = 15'b000010000000000,
        ST_P_WR     = 15'b000100000000000,
        ST_SEL_RD   = 15'b001000000000000,
        ST_SEL_CMP  = 15'b010000000000000,
        ST_SEL_EMIT = 15'b100000000000000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [N_W-1:0]     node_count_reg;
    logic [D_W-1:0]     damping_reg;
    logic [15:0]        threshold_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= N_W'(64);
            damping_reg    <= 16'd55706;
            threshold_reg  <= 16'd7;
            max_iter_reg   <= 10'd100;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                trk_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[N_W-1:0];
                trk_pkg::CFG_DAMPING:    damping_reg    <= cfg_data;
                trk_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data;
                trk_pkg::CFG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ---------------- control and datapath registers ----------------
    state_t                     state_reg, state_next;
    logic [N_W-1:0]             n_reg, n_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic                       bank_reg, bank_next;
    logic [ITER_W-1:0]          pass_reg, pass_next;
    logic                       conv_reg, conv_next;
    logic                       cflag_reg, cflag_next;
    logic [trk_pkg::MAX_NODES-1:0] taken_reg, taken_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           best_idx_reg, best_idx_next;
    logic signed [SCORE_W-1:0]  best_reg, best_next;

    logic signed [RS_W-1:0]     sum_reg, sum_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [RS_W-1:0]            rs_reg, rs_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SCORE_W-1:0]  old_reg, old_next;
    logic signed [HI_W+D_W:0]   hi_reg, hi_next;
    logic [LO_W+D_W-1:0]        lo_reg, lo_next;
    logic signed [ACC_W-1:0]    scaled_reg, scaled_next;

    logic                       out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]           out_node_reg, out_node_next;
    logic signed [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_conv_reg, out_conv_next;
    logic [ITER_W-1:0]          out_iter_reg, out_iter_next;

    // ---------------- memories ----------------
    logic signed [SIM_W-1:0]    sim_mem [trk_pkg::MAX_NODES*trk_pkg::MAX_NODES];
    logic signed [RS_W-1:0]     rs_mem [trk_pkg::MAX_NODES];
    logic signed [SCORE_W-1:0]  score_mem [2*trk_pkg::MAX_NODES];

    logic                       sim_we;
    logic [2*IDX_W-1:0]         sim_waddr, sim_raddr;
    logic signed [SIM_W-1:0]    sim_rdata;
    logic                       rs_we;
    logic [IDX_W-1:0]           rs_waddr, rs_raddr;
    logic signed [RS_W-1:0]     rs_wdata, rs_rdata;
    logic                       sc_we;
    logic [IDX_W:0]             sc_waddr, sc_raddr;
    logic signed [SCORE_W-1:0]  sc_wdata, sc_rdata;

    always_ff @(posedge clk)
    begin
        if (sim_we)
        begin
            sim_mem[sim_waddr] <= similarity;
        end
        sim_rdata <= sim_mem[sim_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_rdata <= rs_mem[rs_raddr];
    end

    // two banks: passes read the current bank and write the other one,
    // so a read never meets a write to the same entry
    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            score_mem[sc_waddr] <= sc_wdata;
        end
        sc_rdata <= score_mem[sc_raddr];
    end

    // ---------------- divider ----------------
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [MAG_W-1:0]           div_q;
    logic [PROD_W-1:0]          prod_abs;

    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    trk_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (rs_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- combinational helpers ----------------
    logic                       in_fire;
    logic                       emit_fire;
    logic                       i_last, j_last, k_last;
    logic [N_W-1:0]             n_active;
    logic signed [ACC_W-1:0]    q_term;
    logic signed [TOT_W-1:0]    total;
    logic signed [TOT_W-1:0]    total_adj;
    logic signed [NV_W-1:0]     nv_wide;
    logic signed [SCORE_W-1:0]  nv_sat;
    logic signed [DIF_W-1:0]    diff;
    logic [DIF_W-1:0]           diff_abs;
    logic                       moved;
    logic                       rs_pos;
    logic [ITER_W-1:0]          pass_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (state_reg == ST_SEL_EMIT) && (!out_valid_reg || out_ready);

    assign n_active = (node_count_reg == '0) ? N_W'(1) :
                      (node_count_reg > N_W'(trk_pkg::MAX_NODES)) ?
                      N_W'(trk_pkg::MAX_NODES) : node_count_reg;

    assign i_last = ({1'b0, i_reg} == n_reg - 1'b1);
    assign j_last = ({1'b0, j_reg} == n_reg - 1'b1);
    assign k_last = ({1'b0, k_reg} == n_reg - 1'b1);

    assign rs_pos   = !rs_rdata[RS_W-1] && (rs_rdata != '0);
    assign q_term   = prod_reg[PROD_W-1] ? -ACC_W'({1'b0, div_q}) : ACC_W'({1'b0, div_q});

    // d*acc from two partial products, then truncate toward zero by 2^16
    assign total     = (TOT_W'(hi_reg) <<< LO_W) + TOT_W'({1'b0, lo_reg});
    assign total_adj = total + (total[TOT_W-1] ? TOT_W'(65535) : TOT_W'(0));

    assign nv_wide = NV_W'(scaled_reg) + NV_W'(19'sd65536 - $signed({3'b000, damping_reg}));
    assign nv_sat  = (nv_wide > NV_W'(trk_pkg::SCORE_MAX)) ? trk_pkg::SCORE_MAX :
                     (nv_wide < NV_W'(trk_pkg::SCORE_MIN)) ? trk_pkg::SCORE_MIN :
                     nv_wide[SCORE_W-1:0];
    assign diff     = DIF_W'(nv_sat) - DIF_W'(old_reg);
    assign diff_abs = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
    assign moved    = (diff_abs > DIF_W'(threshold_reg));
    assign pass_inc = pass_reg + 1'b1;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        bank_next      = bank_reg;
        pass_next      = pass_reg;
        conv_next      = conv_reg;
        cflag_next     = cflag_reg;
        taken_next     = taken_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        rs_next        = rs_reg;
        acc_next       = acc_reg;
        old_next       = old_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        scaled_next    = scaled_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_node_next  = out_node_reg;
        out_score_next = out_score_reg;
        out_last_next  = out_last_reg;
        out_conv_next  = out_conv_reg;
        out_iter_next  = out_iter_reg;

        sim_we    = 1'b0;
        sim_waddr = {row, col};
        sim_raddr = {j_reg, i_reg};
        rs_we     = 1'b0;
        rs_waddr  = j_reg;
        rs_wdata  = sum_reg + RS_W'(sim_rdata);
        rs_raddr  = j_reg;
        sc_we     = 1'b0;
        sc_waddr  = {bank_reg, j_reg};
        sc_wdata  = trk_pkg::ONE_Q16;
        sc_raddr  = {bank_reg, j_reg};
        div_start = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == trk_pkg::OP_LOAD)
                    begin
                        sim_we = 1'b1;
                    end
                    else
                    begin
                        n_next     = n_active;
                        i_next     = '0;
                        j_next     = '0;
                        sum_next   = '0;
                        pass_next  = '0;
                        conv_next  = 1'b0;
                        state_next = ST_RS_RD;
                    end
                end
            end

            ST_RS_RD:
            begin
                state_next = ST_RS_ACC;
            end

            // accumulate one row; at its end store the sum and seed the score
            ST_RS_ACC:
            begin
                sum_next = sum_reg + RS_W'(sim_rdata);
                if (i_last)
                begin
                    rs_we    = 1'b1;
                    sc_we    = 1'b1;
                    sum_next = '0;
                    i_next   = '0;
                    if (j_last)
                    begin
                        j_next     = '0;
                        acc_next   = '0;
                        cflag_next = 1'b1;
                        if (max_iter_reg == '0)
                        begin
                            taken_next = '0;
                            found_next = 1'b0;
                            k_next     = '0;
                            state_next = ST_SEL_RD;
                        end
                        else
                        begin
                            state_next = ST_P_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_RS_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RS_RD;
                end
            end

            ST_P_RD:
            begin
                state_next = ST_P_MUL;
            end

            ST_P_MUL:
            begin
                if ((j_reg == i_reg) || !rs_pos)
                begin
                    state_next = ST_P_NEXT;
                end
                else
                begin
                    prod_next  = PROD_W'(sim_rdata) * PROD_W'(sc_rdata);
                    rs_next    = rs_rdata;
                    state_next = ST_P_DSTART;
                end
            end

            ST_P_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_P_DWAIT;
            end

            ST_P_DWAIT:
            begin
                if (div_done)
                begin
                    acc_next   = acc_reg + q_term;
                    state_next = ST_P_NEXT;
                end
            end

            ST_P_NEXT:
            begin
                if (j_last)
                begin
                    j_next     = '0;
                    state_next = ST_P_OLD_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_P_RD;
                end
            end

            ST_P_OLD_RD:
            begin
                sc_raddr   = {bank_reg, i_reg};
                state_next = ST_P_MD1;
            end

            ST_P_MD1:
            begin
                old_next   = sc_rdata;
                hi_next    = $signed({1'b0, damping_reg}) * $signed(acc_reg[ACC_W-1:LO_W]);
                lo_next    = damping_reg * acc_reg[LO_W-1:0];
                state_next = ST_P_MD2;
            end

            ST_P_MD2:
            begin
                scaled_next = total_adj[ACC_W+15:16];
                state_next  = ST_P_WR;
            end

            // write the new score to the other bank, fold in the change test
            ST_P_WR:
            begin
                sc_we      = 1'b1;
                sc_waddr   = {!bank_reg, i_reg};
                sc_wdata   = nv_sat;
                cflag_next = cflag_reg && !moved;
                acc_next   = '0;
                if (i_last)
                begin
                    i_next    = '0;
                    bank_next = !bank_reg;
                    pass_next = pass_inc;
                    if ((cflag_reg && !moved) || (pass_inc >= max_iter_reg))
                    begin
                        conv_next  = cflag_reg && !moved;
                        taken_next = '0;
                        found_next = 1'b0;
                        k_next     = '0;
                        state_next = ST_SEL_RD;
                    end
                    else
                    begin
                        cflag_next = 1'b1;
                        state_next = ST_P_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P_RD;
                end
            end

            ST_SEL_RD:
            begin
                sc_raddr   = {bank_reg, i_reg};
                state_next = ST_SEL_CMP;
            end

            // strict compare in ascending order keeps the lower index on ties
            ST_SEL_CMP:
            begin
                if (!taken_reg[i_reg] && (!found_reg || (sc_rdata > best_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = i_reg;
                    best_next     = sc_rdata;
                end
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = ST_SEL_EMIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SEL_RD;
                end
            end

            ST_SEL_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next          = 1'b1;
                    out_node_next           = best_idx_reg;
                    out_score_next          = best_reg;
                    out_last_next           = k_last;
                    out_conv_next           = conv_reg;
                    out_iter_next           = pass_reg;
                    taken_next[best_idx_reg] = 1'b1;
                    found_next              = 1'b0;
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SEL_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= N_W'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            bank_reg      <= 1'b0;
            pass_reg      <= '0;
            conv_reg      <= 1'b0;
            cflag_reg     <= 1'b0;
            taken_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            bank_reg      <= bank_next;
            pass_reg      <= pass_next;
            conv_reg      <= conv_next;
            cflag_reg     <= cflag_next;
            taken_reg     <= taken_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        sum_reg       <= sum_next;
        prod_reg      <= prod_next;
        rs_reg        <= rs_next;
        acc_reg       <= acc_next;
        old_reg       <= old_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        scaled_reg    <= scaled_next;
        out_node_reg  <= out_node_next;
        out_score_reg <= out_score_next;
        out_last_reg  <= out_last_next;
        out_conv_reg  <= out_conv_next;
        out_iter_reg  <= out_iter_next;
    end

    assign out_valid       = out_valid_reg;
    assign node_index      = out_node_reg;
    assign score           = out_score_reg;
    assign is_last         = out_last_reg;
    assign converged       = out_conv_reg;
    assign iterations_used = out_iter_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pick_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (found_reg && !taken_reg[best_idx_reg]))
        else $error("selected node already emitted");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && k_last) |=> (state_reg == ST_IDLE) && out_valid_reg && is_last)
        else $error("last ranked item did not close the run");
`endif

endmodule

`default_nettype wire

// ===== tb/textrank_power_iteration_ranker_top_test.sv =====
// ---------------------------------------------------------------------------
// textrank_power_iteration_ranker_top_test: self-checking bench for the ranker
// Loads similarity matrices, runs ranking passes under many register settings
// and checks every ranked node against a typed result or a power-iteration model.
// ---------------------------------------------------------------------------
`default_nettype none

module textrank_power_iteration_ranker_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL      = 310;
    localparam int STALL_LIMIT    = 200000;   // slowest run: 8 nodes, 8 passes
    localparam int SETTLE_CYCLES  = 8;

    // short names for the directed table
    localparam trk_pkg::cfg_index_t R_NODES = trk_pkg::CFG_NODE_COUNT;
    localparam trk_pkg::cfg_index_t R_DAMP  = trk_pkg::CFG_DAMPING;
    localparam trk_pkg::cfg_index_t R_THR   = trk_pkg::CFG_THRESHOLD;
    localparam trk_pkg::cfg_index_t R_ITER  = trk_pkg::CFG_MAX_ITER;
    localparam trk_pkg::opcode_t    LD      = trk_pkg::OP_LOAD;
    localparam trk_pkg::opcode_t    RN      = trk_pkg::OP_RUN;

    typedef struct packed {
        logic [5:0]         node;
        logic signed [23:0] score;
        logic               last;
        logic               conv;
        logic [9:0]         iters;
    } rank_entry_t;

    // one row of the directed sequence: a register write or an item
    typedef struct {
        bit                  is_cfg;
        trk_pkg::cfg_index_t idx;
        logic [15:0]         data;
        trk_pkg::opcode_t    op;
        logic [5:0]          r;
        logic [5:0]          c;
        logic signed [15:0]  s;
        bit                  typed;        // expected result typed in below
        logic signed [23:0]  sc;
        bit                  cv;
        logic [9:0]          it;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    trk_pkg::opcode_t    opcode;
    logic [5:0]          row;
    logic [5:0]          col;
    logic signed [15:0]  similarity;
    logic                out_valid;
    logic                out_ready;
    logic [5:0]          node_index;
    logic signed [23:0]  score;
    logic                is_last;
    logic                converged;
    logic [9:0]          iterations_used;
    logic                cfg_write;
    trk_pkg::cfg_index_t cfg_index;
    logic [15:0]         cfg_data;

    textrank_power_iteration_ranker_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .row             (row),
        .col             (col),
        .similarity      (similarity),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .node_index      (node_index),
        .score           (score),
        .is_last         (is_last),
        .converged       (converged),
        .iterations_used (iterations_used),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Mirror of the matrix and registers kept by the bench
    shortint     sim_mem [64][64];
    bit          written [64][64];
    logic [6:0]  node_reg;
    logic [15:0] damp_reg;
    logic [15:0] thr_reg;
    logic [9:0]  iter_reg;

    rank_entry_t ranked_q[$];     // ranked nodes still awaited from the block
    int          mismatches;
    int          items_sent;
    int          idle_cycles;
    bit          quiet;           // no gaps on either side while set
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Ranking model: row sums, damped passes, then a stable descending sort
    // -----------------------------------------------------------------------
    function automatic void predict_ranking();
        int          n;
        longint      rsum [64];
        longint      cur [64];
        longint      nxt [64];
        bit          taken [64];
        longint      acc;
        longint      nv;
        longint      diff;
        longint      d;
        bit          conv;
        bit          settled;
        int          passes;
        int          best;
        bit          found;
        rank_entry_t e;

        n = (node_reg == 0) ? 1 : (node_reg > 64) ? 64 : int'(node_reg);
        d = longint'(damp_reg);
        for (int j = 0; j < n; j++)
        begin
            rsum[j] = 0;
            for (int i = 0; i < n; i++)
                rsum[j] += sim_mem[j][i];
            cur[j] = 65536;
            taken[j] = 1'b0;
        end
        conv = 1'b0;
        passes = 0;
        while (passes < int'(iter_reg))
        begin
            passes++;
            settled = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    if (j != i && rsum[j] > 0)
                        acc += (longint'(sim_mem[j][i]) * cur[j]) / rsum[j];
                nv = (65536 - d) + (d * acc) / 65536;
                if (nv > 8388607)
                    nv = 8388607;
                if (nv < -8388608)
                    nv = -8388608;
                nxt[i] = nv;
                diff = nv - cur[i];
                if (diff < 0)
                    diff = -diff;
                if (diff > longint'(thr_reg))
                    settled = 1'b0;
            end
            for (int i = 0; i < n; i++)
                cur[i] = nxt[i];
            if (settled)
            begin
                conv = 1'b1;
                break;
            end
        end
        // pick the highest remaining score; strict compare keeps the lower index
        for (int k = 0; k < n; k++)
        begin
            best = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++)
                if (!taken[i] && (!found || cur[i] > cur[best]))
                begin
                    best = i;
                    found = 1'b1;
                end
            taken[best] = 1'b1;
            e.node  = best[5:0];
            e.score = cur[best][23:0];
            e.last  = (k == n - 1);
            e.conv  = conv;
            e.iters = passes[9:0];
            ranked_q.push_back(e);
        end
    endfunction

    // Mostly back-to-back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (quiet || roll < 11)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        if (roll == 18)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Mostly positive entries so that row sums count; some across the full word
    function automatic logic signed [15:0] pick_similarity();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'($urandom_range(0, 16384));
        if (roll < 9)
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        return 16'($urandom_range(0, 65535));
    endfunction

    // Present one item; hold it until accepted, then update the model
    task automatic send_item(input trk_pkg::opcode_t op, input logic [5:0] r,
                             input logic [5:0] c, input logic signed [15:0] s,
                             input bit typed, input rank_entry_t typed_entry);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        row        <= r;
        col        <= c;
        similarity <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (op == trk_pkg::OP_LOAD)
        begin
            sim_mem[r][c] = s;
            written[r][c] = 1'b1;
        end
        else if (typed)
            ranked_q.push_back(typed_entry);
        else
            predict_ranking();
    endtask

    // Drop valid and wait until every ranked node has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input trk_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            trk_pkg::CFG_NODE_COUNT: node_reg = value[6:0];
            trk_pkg::CFG_DAMPING:    damp_reg = value;
            trk_pkg::CFG_THRESHOLD:  thr_reg  = value;
            trk_pkg::CFG_MAX_ITER:   iter_reg = value[9:0];
            default: ;
        endcase
    endtask

    // Load every entry of the active square that was never written
    task automatic fill_active(input int n);
        rank_entry_t none;
        none = '0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!written[r][c])
                    send_item(trk_pkg::OP_LOAD, r[5:0], c[5:0], pick_similarity(),
                              1'b0, none);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field compare
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        rank_entry_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (ranked_q.size() == 0)
                begin
                    $error("ranked node %0d arrived with none expected", node_index);
                    mismatches++;
                end
                else
                begin
                    e = ranked_q.pop_front();
                    if (node_index !== e.node)
                    begin
                        $error("node_index expected %0d got %0d", e.node, node_index);
                        mismatches++;
                    end
                    if (score !== e.score)
                    begin
                        $error("score expected %0d got %0d", e.score, score);
                        mismatches++;
                    end
                    if (is_last !== e.last)
                    begin
                        $error("is_last expected %0d got %0d", e.last, is_last);
                        mismatches++;
                    end
                    if (converged !== e.conv)
                    begin
                        $error("converged expected %0d got %0d", e.conv, converged);
                        mismatches++;
                    end
                    if (iterations_used !== e.iters)
                    begin
                        $error("iterations_used expected %0d got %0d",
                               e.iters, iterations_used);
                        mismatches++;
                    end
                end
            end
            // back-pressure: short stalls mostly, a long one now and then
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (quiet || $urandom_range(0, 9) < 7)
                out_ready <= 1'b1;
            else
            begin
                out_ready  <= 1'b0;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                           : $urandom_range(0, 2);
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        step_t       directed [];
        rank_entry_t te;
        int          n;
        int          runs;
        int          reloads;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = trk_pkg::OP_LOAD;
        row        = '0;
        col        = '0;
        similarity = '0;
        out_ready  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = trk_pkg::CFG_NODE_COUNT;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        idle_cycles = 0;
        quiet      = 1'b0;
        stall_left = 0;
        node_reg   = 7'd64;
        damp_reg   = 16'd55706;
        thr_reg    = 16'd7;
        iter_reg   = 10'd100;
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 64; c++)
            begin
                sim_mem[r][c] = 0;
                written[r][c] = 1'b0;
            end

        // Directed part. A single node has no neighbors, so its score is just
        // 1 - d; it converges on the second pass unless d is zero.
        directed = '{
            '{1, R_NODES, 16'd1,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd0,  6'd0,  16'sd16384,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      1, 9830,   1, 2},
            // no passes at all: every score stays at 1.0
            '{1, R_ITER,  16'd0,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      1, 65536,  0, 0},
            '{1, R_ITER,  16'd100,   LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{1, R_DAMP,  16'd0,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      1, 65536,  1, 1},
            '{1, R_DAMP,  16'd65535, LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      1, 1,      1, 2},
            '{1, R_DAMP,  16'd55706, LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{1, R_NODES, 16'd2,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{1, R_ITER,  16'd1023,  LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{1, R_THR,   16'd0,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            // both row sums nonpositive: no contributions, equal scores tie
            '{0, R_NODES, 16'd0,     LD, 6'd0,  6'd0, -16'sd16384,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd0,  6'd1,  16'sd16384,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd1,  6'd0, -16'sd16384,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd1,  6'd1, -16'sd16384,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            // entries beyond +-1.0 are used as given
            '{0, R_NODES, 16'd0,     LD, 6'd0,  6'd1,  16'sd32767,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd1,  6'd0, -16'sd32768,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd1,  6'd1,  16'sd32767,  0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd63, 6'd63, -16'sd1,     0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     LD, 6'd42, 6'd21,  16'sd21845, 0, 0,      0, 0},
            // node count zero behaves as one node
            '{1, R_THR,   16'd65535, LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{1, R_NODES, 16'd0,     LD, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0},
            '{0, R_NODES, 16'd0,     RN, 6'd0,  6'd0,  16'sd0,      0, 0,      0, 0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
            begin
                wait_idle();
                write_reg(directed[k].idx, directed[k].data);
            end
            else
            begin
                te.node  = 6'd0;
                te.score = directed[k].sc;
                te.last  = 1'b1;
                te.conv  = directed[k].cv;
                te.iters = directed[k].it;
                send_item(directed[k].op, directed[k].r, directed[k].c, directed[k].s,
                          directed[k].typed, te);
            end
        end

        // Random part: phases of register settings, each with a few runs over
        // a fully loaded matrix whose entries are partly rewritten in between.
        te = '0;
        while (items_sent < ITEM_GOAL)
        begin
            wait_idle();
            quiet = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
            write_reg(trk_pkg::CFG_NODE_COUNT,
                      (n == 1 && $urandom_range(0, 3) == 0) ? 16'd0 : 16'(n));
            case ($urandom_range(0, 5))
                0:       write_reg(trk_pkg::CFG_DAMPING, 16'd0);
                1:       write_reg(trk_pkg::CFG_DAMPING, 16'd65535);
                default: write_reg(trk_pkg::CFG_DAMPING, 16'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(trk_pkg::CFG_THRESHOLD, 16'd0);
                1:       write_reg(trk_pkg::CFG_THRESHOLD, 16'd65535);
                2:       write_reg(trk_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
                default: write_reg(trk_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 300)));
            endcase
            if (n <= 3 && $urandom_range(0, 4) == 0)
                write_reg(trk_pkg::CFG_MAX_ITER, 16'($urandom_range(20, 60)));
            else
                write_reg(trk_pkg::CFG_MAX_ITER, 16'($urandom_range(0, 8)));

            runs = $urandom_range(1, 3);
            for (int k = 0; k < runs; k++)
            begin
                fill_active(n);
                reloads = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, n * n);
                for (int m = 0; m < reloads; m++)
                    send_item(trk_pkg::OP_LOAD, 6'($urandom_range(0, n - 1)),
                              6'($urandom_range(0, n - 1)), pick_similarity(), 1'b0, te);
                send_item(trk_pkg::OP_RUN, 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                          1'b0, te);
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
